// File: rtl/awnm_pkg.sv
// awnm_pkg: widths, constants and request structs of the adaptive weighted
// neighbour mean unit
// no dependencies

package awnm_pkg;

  localparam int unsigned SigW   = 24;
  localparam int unsigned W2W    = 21;
  localparam int unsigned W1W    = 25;
  localparam int unsigned RatW   = 23;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SumW   = 30;

  localparam int unsigned MulAW  = 25;
  localparam int unsigned MulBW  = 30;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned TmpW   = 36;
  localparam int unsigned DvsW   = 33;
  localparam int unsigned DvdW   = 56;
  localparam int unsigned DivCntW = 6;

  localparam logic [CntW-1:0]    MaxNbr   = 7'd64;
  localparam logic [W2W-1:0]     W2Reset  = 21'd65536;
  localparam logic [W1W-1:0]     OneQ16   = 25'd65536;
  localparam logic [W1W-1:0]     W1Max    = 25'h1ff_ffff;
  localparam logic [SigW-1:0]    SigMax   = 24'hff_ffff;
  localparam logic [MulBW-1:0]   KNum     = 30'd228;
  localparam logic [MulBW-1:0]   KDen     = 30'd625;

  localparam logic [DivCntW-1:0] RatioSteps = 6'd23;
  localparam logic [DivCntW-1:0] W1Steps    = 6'd36;
  localparam logic [DivCntW-1:0] MeanSteps  = 6'd56;

  typedef struct packed {
    logic [SigW-1:0] neighbour_signal;
    logic            same_type;
    logic            excluded;
    logic            last_neighbour;
    logic            no_neighbours;
  } awnm_in_t;

  typedef struct packed {
    logic [SigW-1:0] mean_signal;
    logic [W1W-1:0]  same_weight;
    logic [RatW-1:0] type_ratio;
  } awnm_out_t;

endpackage

// File: rtl/adaptive_weighted_neighbour_mean_unit.sv
// adaptive_weighted_neighbour_mean_unit: per-cell weighted neighbour mean
// with adaptive same-type weight, built on one shared multiplier and divider
// depends on awnm_pkg
//
// usage
//   input channel (in_valid_i / in_stall_o / in_data_i) takes one neighbour
//   request per cycle while in_stall_o is low; excluded neighbours are dropped,
//   others are counted and summed by type. a request with last_neighbour starts
//   the result sequence: one radix-2 restoring divider and one 25x30 multiplier
//   stepped by a small sequencer. with both counts nonzero it runs the ratio,
//   weight and mean divisions; with one count zero only the mean division; an
//   empty neighbour set goes straight to the result register; a zero weighted
//   count skips the mean division.
//   in_stall_o is high while the sequence runs and while a finished result
//   waits for a stalled output register.
//   output channel (out_valid_o / out_stall_i / out_data_o) is a register;
//   a stalled result holds while the next cell's neighbours are accepted.
//   config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes w2 and is
//   always ready; write only while idle.
//   reset clears counts, sums, held ratio and output valid; w2 returns to 1.0.

module adaptive_weighted_neighbour_mean_unit import awnm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  awnm_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output awnm_out_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [W2W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_ACC = 4'b0001,
    ST_SEQ = 4'b0010,
    ST_DIV = 4'b0100,
    ST_OUT = 4'b1000
  } state_e;

  typedef enum logic [9:0] {
    SP_RATIO = 10'b00_0000_0001,
    SP_W2K   = 10'b00_0000_0010,
    SP_WDC   = 10'b00_0000_0100,
    SP_SC625 = 10'b00_0000_1000,
    SP_W1    = 10'b00_0001_0000,
    SP_DEN0  = 10'b00_0010_0000,
    SP_DEN1  = 10'b00_0100_0000,
    SP_NUM0  = 10'b00_1000_0000,
    SP_NUM1  = 10'b01_0000_0000,
    SP_MEAN  = 10'b10_0000_0000
  } step_e;

  state_e              state_q, state_d;
  step_e               step_q, step_d;
  logic [CntW-1:0]     sc_q, sc_d, dc_q, dc_d;
  logic [SumW-1:0]     ss_q, ss_d, ds_q, ds_d;
  logic [RatW-1:0]     ratio_q, ratio_d;
  logic [W2W-1:0]      w2_q, w2_d;
  logic                out_valid_q, out_valid_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;

  logic [TmpW-1:0]     tmp_q, tmp_d;
  logic [DvsW-1:0]     dvs_q, dvs_d;
  logic [DvsW-1:0]     den_q, den_d;
  logic [DvdW-1:0]     num_q, num_d;
  logic [DvsW-1:0]     rem_q, rem_d;
  logic [DvdW-1:0]     quo_q, quo_d;
  logic [W1W-1:0]      w1_q, w1_d;
  logic [SigW-1:0]     mean_q, mean_d;
  awnm_out_t           out_q, out_d;

  logic                in_acc, take, out_free;
  logic [CntW-1:0]     cnt_tot, sc_nx, dc_nx;
  logic [MulAW-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [ProdW-1:0]    prod;
  logic [DvsW:0]       rem_sh, dvs_ext, rem_sub;
  logic                ge;
  logic [DvsW-1:0]     rem_nx;
  logic [DvdW-1:0]     quo_nx;

  assign in_stall_o  = (state_q != ST_ACC);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_acc   = in_valid_i && (state_q == ST_ACC);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_tot  = sc_q + dc_q;
  assign take     = in_acc && !in_data_i.no_neighbours && !in_data_i.excluded &&
                    (cnt_tot < MaxNbr);
  assign sc_nx    = sc_q + CntW'(take && in_data_i.same_type);
  assign dc_nx    = dc_q + CntW'(take && !in_data_i.same_type);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      SP_W2K:   begin mul_a = MulAW'(w2_q); mul_b = KNum; end
      SP_WDC:   begin mul_a = MulAW'(dc_q); mul_b = tmp_q[MulBW-1:0]; end
      SP_SC625: begin mul_a = MulAW'(sc_q); mul_b = KDen; end
      SP_DEN0:  begin mul_a = w1_q; mul_b = MulBW'(sc_q); end
      SP_DEN1:  begin mul_a = MulAW'(w2_q); mul_b = MulBW'(dc_q); end
      SP_NUM0:  begin mul_a = w1_q; mul_b = ss_q; end
      SP_NUM1:  begin mul_a = MulAW'(w2_q); mul_b = ds_q; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // shared restoring divider step
  assign rem_sh  = {rem_q, quo_q[DvdW-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = (rem_sh >= dvs_ext);
  assign rem_sub = rem_sh - dvs_ext;
  assign rem_nx  = ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
  assign quo_nx  = {quo_q[DvdW-2:0], ge};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sc_d        = sc_q;
    dc_d        = dc_q;
    ss_d        = ss_q;
    ds_d        = ds_q;
    ratio_d     = ratio_q;
    w2_d        = w2_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    tmp_d       = tmp_q;
    dvs_d       = dvs_q;
    den_d       = den_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    w1_d        = w1_q;
    mean_d      = mean_q;
    out_d       = out_q;

    if (cfg_valid_i) begin
      w2_d = cfg_data_i;
    end
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_ACC: begin
        if (in_acc) begin
          if (in_data_i.no_neighbours) begin
            mean_d  = '0;
            w1_d    = '0;
            state_d = ST_OUT;
          end else begin
            sc_d = sc_nx;
            dc_d = dc_nx;
            if (take && in_data_i.same_type) begin
              ss_d = ss_q + SumW'(in_data_i.neighbour_signal);
            end
            if (take && !in_data_i.same_type) begin
              ds_d = ds_q + SumW'(in_data_i.neighbour_signal);
            end
            if (in_data_i.last_neighbour) begin
              state_d = ST_SEQ;
              if ((sc_nx == '0) || (dc_nx == '0)) begin
                w1_d   = OneQ16;
                step_d = SP_DEN0;
              end else begin
                step_d = SP_RATIO;
              end
            end
          end
        end
      end
      ST_SEQ: begin
        unique case (step_q)
          SP_RATIO: begin
            dvs_d   = DvsW'(dc_q);
            rem_d   = '0;
            quo_d   = {sc_q, 16'h0, 33'h0};
            cnt_d   = RatioSteps;
            state_d = ST_DIV;
          end
          SP_W2K: begin
            tmp_d  = prod[TmpW-1:0];
            step_d = SP_WDC;
          end
          SP_WDC: begin
            tmp_d  = prod[TmpW-1:0];
            step_d = SP_SC625;
          end
          SP_SC625: begin
            dvs_d  = prod[DvsW-1:0];
            step_d = SP_W1;
          end
          SP_W1: begin
            rem_d   = '0;
            quo_d   = {tmp_q, 20'h0};
            cnt_d   = W1Steps;
            state_d = ST_DIV;
          end
          SP_DEN0: begin
            den_d  = prod[DvsW-1:0];
            step_d = SP_DEN1;
          end
          SP_DEN1: begin
            den_d  = den_q + prod[DvsW-1:0];
            step_d = SP_NUM0;
          end
          SP_NUM0: begin
            num_d  = DvdW'(prod);
            step_d = SP_NUM1;
          end
          SP_NUM1: begin
            num_d  = num_q + DvdW'(prod);
            step_d = SP_MEAN;
          end
          SP_MEAN: begin
            if (den_q == '0) begin
              mean_d  = '0;
              state_d = ST_OUT;
            end else begin
              dvs_d   = den_q;
              rem_d   = '0;
              quo_d   = num_q;
              cnt_d   = MeanSteps;
              state_d = ST_DIV;
            end
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          state_d = ST_SEQ;
          case (step_q)
            SP_RATIO: begin
              ratio_d = quo_nx[RatW-1:0];
              step_d  = SP_W2K;
            end
            SP_W1: begin
              w1_d   = (quo_nx[TmpW-1:W1W] != '0) ? W1Max : quo_nx[W1W-1:0];
              step_d = SP_DEN0;
            end
            default: begin
              mean_d  = (quo_nx[DvdW-1:SigW] != '0) ? SigMax : quo_nx[SigW-1:0];
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.mean_signal = mean_q;
          out_d.same_weight = w1_q;
          out_d.type_ratio  = ratio_q;
          out_valid_d       = 1'b1;
          sc_d              = '0;
          dc_d              = '0;
          ss_d              = '0;
          ds_d              = '0;
          state_d           = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= SP_RATIO;
      sc_q        <= '0;
      dc_q        <= '0;
      ss_q        <= '0;
      ds_q        <= '0;
      ratio_q     <= '0;
      w2_q        <= W2Reset;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sc_q        <= sc_d;
      dc_q        <= dc_d;
      ss_q        <= ss_d;
      ds_q        <= ds_d;
      ratio_q     <= ratio_d;
      w2_q        <= w2_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    dvs_q  <= dvs_d;
    den_q  <= den_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    w1_q   <= w1_d;
    mean_q <= mean_d;
    out_q  <= out_d;
  end

  // neighbour count stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_q + dc_q) <= MaxNbr)
    else $error("neighbour count above limit");

  // divider never runs on a zero divisor and keeps its remainder below it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dvs_q != '0) && (rem_q < dvs_q))
    else $error("divider remainder or divisor out of range");

  // issuing a result clears the cell and raises output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && out_free |=>
      out_valid_q && (sc_q == '0) && (dc_q == '0) && (ss_q == '0) && (ds_q == '0))
    else $error("cell not cleared after result");

  // input is only taken while no result sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEQ) || (state_q == ST_DIV) |-> in_stall_o)
    else $error("input taken during result sequence");

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for adaptive_weighted_neighbour_mean_unit
// holds a scoreboard class that predicts each cell result and drives the block with
// random stalls; depends on awnm_pkg and the unit rtl
`timescale 1ns / 1ps

import awnm_pkg::*;

class mean_tracker;
  logic [W2W-1:0]  diff_weight;
  logic [CntW-1:0] same_cnt;
  logic [CntW-1:0] diff_cnt;
  logic [SumW-1:0] same_sum;
  logic [SumW-1:0] diff_sum;
  logic [RatW-1:0] held_ratio;
  awnm_out_t       awaited_means[$];
  int unsigned     failures;

  function new();
    diff_weight = W2Reset;
    held_ratio  = '0;
    failures    = 0;
    clear_cell();
  endfunction

  function void clear_cell();
    same_cnt = '0;
    diff_cnt = '0;
    same_sum = '0;
    diff_sum = '0;
  endfunction

  function void note_request(awnm_in_t req);
    longint unsigned w1, w2, s, d, denom, num, mean;
    awnm_out_t res;
    w2 = diff_weight;
    if (req.no_neighbours) begin
      clear_cell();
      res.mean_signal = '0;
      res.same_weight = '0;
      res.type_ratio  = held_ratio;
      awaited_means.push_back(res);
      return;
    end
    if (!req.excluded && int'(same_cnt) + int'(diff_cnt) < int'(MaxNbr)) begin
      if (req.same_type) begin
        same_cnt++;
        same_sum += req.neighbour_signal;
      end else begin
        diff_cnt++;
        diff_sum += req.neighbour_signal;
      end
    end
    if (!req.last_neighbour) return;
    s = same_cnt;
    d = diff_cnt;
    if (s == 0 || d == 0) begin
      w1 = OneQ16;
    end else begin
      held_ratio = RatW'((s << 16) / d);
      w1 = (KNum * w2 * d) / (KDen * s);
      if (w1 > W1Max) w1 = W1Max;
    end
    denom = s * w1 + d * w2;
    mean = 0;
    if (denom != 0) begin
      num = w1 * same_sum + w2 * diff_sum;
      mean = num / denom;
      if (mean > SigMax) mean = SigMax;
    end
    res.mean_signal = SigW'(mean);
    res.same_weight = W1W'(w1);
    res.type_ratio  = held_ratio;
    awaited_means.push_back(res);
    clear_cell();
  endfunction

  function void compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_result(awnm_out_t got);
    awnm_out_t want;
    if (awaited_means.size() == 0) begin
      $display("%0t: result expected none actual %h", $time, got);
      failures++;
      return;
    end
    want = awaited_means.pop_front();
    compare_field("mean_signal", want.mean_signal, got.mean_signal);
    compare_field("same_weight", want.same_weight, got.same_weight);
    compare_field("type_ratio", want.type_ratio, got.type_ratio);
  endfunction
endclass

module tb_top;
  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  awnm_in_t       in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  awnm_out_t      out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [W2W-1:0] cfg_data_i;

  mean_tracker tracker;
  bit          in_gaps_on = 1'b1;
  bit          out_gaps_on = 1'b1;
  int          hold_left = 0;
  int          items_sent = 0;

  adaptive_weighted_neighbour_mean_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= out_gaps_on && ($urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
  end

  function automatic awnm_in_t mk(logic [SigW-1:0] sig, bit same, bit excl, bit fin,
                                  bit empty);
    awnm_in_t req;
    req.neighbour_signal = sig;
    req.same_type        = same;
    req.excluded         = excl;
    req.last_neighbour   = fin;
    req.no_neighbours    = empty;
    return req;
  endfunction

  function automatic logic [SigW-1:0] pick_signal();
    case ($urandom_range(9))
      0: return '0;
      1: return SigMax;
      default: return SigW'($urandom_range(SigMax));
    endcase
  endfunction

  task automatic send_request(input awnm_in_t req);
    @(negedge clk_i);
    while (in_gaps_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(req);
    items_sent++;
  endtask

  task automatic send_cell();
    int       n;
    int       same_pct;
    awnm_in_t req;
    n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
    case ($urandom_range(3))
      0: same_pct = 0;
      1: same_pct = 100;
      default: same_pct = $urandom_range(100);
    endcase
    for (int k = 1; k <= n; k++) begin
      req = mk(pick_signal(), $urandom_range(99) < same_pct, $urandom_range(6) == 0,
               k == n, 1'b0);
      // broken cell: empty-set request at a random position within a cell
      if ($urandom_range(39) == 0) begin
        req.no_neighbours  = 1'b1;
        req.last_neighbour = $urandom_range(1);
      end
      send_request(req);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.awaited_means.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [W2W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.diff_weight = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [W2W-1:0] weights [6];
    int             wait_cycles;
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed cells at the reset weight
    send_request(mk('0, 0, 0, 0, 1));
    send_request(mk(SigMax, 1, 0, 1, 0));
    send_request(mk('0, 0, 0, 1, 0));
    send_request(mk(SigMax, 1, 1, 1, 0));
    send_request(mk(SigMax, 1, 0, 0, 0));
    send_request(mk(SigMax, 0, 0, 0, 0));
    send_request(mk(24'd123456, 0, 1, 0, 0));
    send_request(mk(24'd1, 1, 0, 1, 0));
    send_request(mk(SigMax, 0, 0, 0, 0));
    send_request(mk(SigMax, 1, 1, 1, 1));
    send_request(mk(SigMax, 0, 0, 0, 0));
    send_request(mk(SigMax, 1, 0, 1, 0));
    send_request(mk('0, 1, 0, 1, 0));
    send_request(mk(24'h555555, 0, 0, 0, 0));
    send_request(mk(24'haaaaaa, 0, 0, 0, 0));
    send_request(mk(24'h800000, 1, 0, 1, 0));

    weights[0] = 21'd1048576;
    weights[1] = '0;
    weights[2] = W2W'($urandom_range(1048575));
    weights[3] = 21'd1;
    weights[4] = W2W'($urandom_range(1048575));
    weights[5] = W2W'($urandom_range(1048576));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_weight(weights[ph]);
      in_gaps_on  = (ph != 2);
      out_gaps_on = (ph != 2);
      if (ph == 3) begin
        in_gaps_on = 1'b0;
        hold_left  = 700;
      end
      while (items_sent < 16 + (ph + 1) * 134) begin
        if (ph == 3 && hold_left == 0) in_gaps_on = 1'b1;
        send_cell();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (tracker.awaited_means.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (tracker.awaited_means.size() != 0) begin
      $display("%0t: %0d results expected, none arrived", $time,
               tracker.awaited_means.size());
      tracker.failures += tracker.awaited_means.size();
    end
    if (tracker.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
